FILE: hdl/rgb_channel_histogram_unit_defines.svh
// Assertion macros for the RGB channel histogram unit.
// Expects signals named clk and rst in the scope where a macro is used.
`ifndef RGB_CHANNEL_HISTOGRAM_UNIT_DEFINES_SVH
`define RGB_CHANNEL_HISTOGRAM_UNIT_DEFINES_SVH

// Same-cycle implication, skipped while in reset
`define RCH_ASSERT_NOW(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("rgb histogram: same-cycle check failed");

// Next-cycle implication, skipped while in reset
`define RCH_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("rgb histogram: next-cycle check failed");

`endif

FILE: hdl/rch_pkg.sv
// Shared constants and controller/datapath interface types for the
// RGB channel histogram unit. No dependencies.
`default_nettype none

package rch_pkg;

  localparam int NUM_BINS       = 256;
  localparam int BIN_BITS       = 8;
  localparam int COUNT_BITS_DEF = 24;
  localparam int OUT_COUNT_BITS = 24;
  localparam int S_TDATA_BITS   = 40;
  localparam int M_TDATA_BITS   = 80;

  // Request kinds carried on s_tuser
  localparam logic REQ_ACCUM = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic ready;      // input side may take a beat
    logic load_item;  // capture the accepted beat
    logic rd_en;      // look up the three bins
    logic wr_accum;   // write back saturated increments
    logic wr_zero;    // zero the bin that was read
    logic load_out;   // move the counts into the output register
    logic clr_step;   // clearing pass: zero one entry
  } ctl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_read;    // held item is a bin read
    logic clear_flag; // held read asks for a clear
    logic out_free;   // output register can take a result
    logic clr_last;   // clearing pass is at its final entry
  } ctl_sts_t;

endpackage

`default_nettype wire

FILE: hdl/rch_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module rch_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/rch_ctrl.sv
// Sequencing state machine for the RGB channel histogram unit:
// clearing pass, accept, lookup, update. Depends on rch_pkg.
`default_nettype none

module rch_ctrl
  import rch_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  input  wire ctl_sts_t sts,
  output ctl_cmd_t      cmd
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE
  } state_t;

  state_t state;
  state_t state_next;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (sts.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_next = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (!sts.is_read || sts.out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Commands decoded from state
  always_comb begin
    cmd           = '0;
    cmd.ready     = (state == ST_IDLE);
    cmd.load_item = (state == ST_IDLE) && in_valid;
    cmd.rd_en     = (state == ST_LOOKUP);
    cmd.clr_step  = (state == ST_CLEAR);
    cmd.wr_accum  = (state == ST_UPDATE) && !sts.is_read;
    cmd.load_out  = (state == ST_UPDATE) && sts.is_read && sts.out_free;
    cmd.wr_zero   = cmd.load_out && sts.clear_flag;
  end

endmodule

`default_nettype wire

FILE: hdl/rch_datapath.sv
// Datapath of the RGB channel histogram unit: item capture, three bin
// RAMs, saturating increment, clear counter and output register.
// Depends on rch_pkg and rch_ram.
`default_nettype none

module rch_datapath
  import rch_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire ctl_cmd_t                cmd,
  output ctl_sts_t                     sts,
  input  wire logic [S_TDATA_BITS-1:0] in_data,
  input  wire logic                    in_kind,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic      [M_TDATA_BITS-1:0] out_data
);

  // Held item
  logic                item_read;
  logic                item_clear;
  logic [BIN_BITS-1:0] red_s;
  logic [BIN_BITS-1:0] green_s;
  logic [BIN_BITS-1:0] blue_s;
  logic [BIN_BITS-1:0] bin_s;

  logic [BIN_BITS-1:0]   clr_cnt;
  logic [BIN_BITS-1:0]   addr_r, addr_g, addr_b;
  logic                  we;
  logic [COUNT_BITS-1:0] rdata_r, rdata_g, rdata_b;
  logic [COUNT_BITS-1:0] wdata_r, wdata_g, wdata_b;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (&v) ? v : v + COUNT_BITS'(1);
  endfunction

  // Capture the accepted beat
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_read  <= (in_kind == REQ_READ);
      red_s      <= in_data[7:0];
      green_s    <= in_data[15:8];
      blue_s     <= in_data[23:16];
      bin_s      <= in_data[31:24];
      item_clear <= in_data[32];
    end
  end

  // Clearing pass address counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt <= clr_cnt + BIN_BITS'(1);
    end
  end

  // Per-channel address: clear counter, read bin or pixel sample
  always_comb begin
    if (cmd.clr_step) begin
      addr_r = clr_cnt;
      addr_g = clr_cnt;
      addr_b = clr_cnt;
    end else if (item_read) begin
      addr_r = bin_s;
      addr_g = bin_s;
      addr_b = bin_s;
    end else begin
      addr_r = red_s;
      addr_g = green_s;
      addr_b = blue_s;
    end
  end

  // Write-back data
  assign we      = cmd.clr_step || cmd.wr_accum || cmd.wr_zero;
  assign wdata_r = cmd.wr_accum ? sat_inc(rdata_r) : '0;
  assign wdata_g = cmd.wr_accum ? sat_inc(rdata_g) : '0;
  assign wdata_b = cmd.wr_accum ? sat_inc(rdata_b) : '0;

  rch_ram #(.WIDTH(COUNT_BITS), .DEPTH(NUM_BINS)) u_red_ram (
    .clk(clk), .we(we), .waddr(addr_r), .wdata(wdata_r),
    .re(cmd.rd_en), .raddr(addr_r), .rdata(rdata_r)
  );

  rch_ram #(.WIDTH(COUNT_BITS), .DEPTH(NUM_BINS)) u_green_ram (
    .clk(clk), .we(we), .waddr(addr_g), .wdata(wdata_g),
    .re(cmd.rd_en), .raddr(addr_g), .rdata(rdata_g)
  );

  rch_ram #(.WIDTH(COUNT_BITS), .DEPTH(NUM_BINS)) u_blue_ram (
    .clk(clk), .we(we), .waddr(addr_b), .wdata(wdata_b),
    .re(cmd.rd_en), .raddr(addr_b), .rdata(rdata_b)
  );

  // Output register: valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register: counts, low bits only
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data <= {OUT_COUNT_BITS'(rdata_b), OUT_COUNT_BITS'(rdata_g),
                   OUT_COUNT_BITS'(rdata_r), bin_s};
    end
  end

  // Status
  assign sts.is_read    = item_read;
  assign sts.clear_flag = item_clear;
  assign sts.out_free   = !out_valid || out_ready;
  assign sts.clr_last   = (clr_cnt == BIN_BITS'(NUM_BINS - 1));

endmodule

`default_nettype wire

FILE: hdl/rgb_channel_histogram_unit.sv
// Each beat is accepted, looked up and written back before the next one
// is taken: a read-modify-write through the registered-read bin RAMs.
// A read result is loaded into the output register at write-back, which
// stalls until the register is free; the next beat can be taken while a
// result waits there. Reset: synchronous; it starts a clearing pass that
// zeroes all bins, with s_tready low for its length.
`default_nettype none

`include "rgb_channel_histogram_unit_defines.svh"

module rgb_channel_histogram_unit
  import rch_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    s_tvalid,
  output logic                         s_tready,
  // red[7:0], green[15:8], blue[23:16], bin_index[31:24],
  // clear_after_read[32], zero pad[39:33]
  input  wire logic [S_TDATA_BITS-1:0] s_tdata,
  // req_type[0]
  input  wire logic                    s_tuser,
  output logic                         m_tvalid,
  input  wire logic                    m_tready,
  // bin_number[7:0], red_count[31:8], green_count[55:32],
  // blue_count[79:56]
  output logic      [M_TDATA_BITS-1:0] m_tdata
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  rch_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_tvalid), .sts(sts), .cmd(cmd)
  );

  rch_datapath #(.COUNT_BITS(COUNT_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .in_data(s_tdata), .in_kind(s_tuser),
    .out_valid(m_tvalid), .out_ready(m_tready), .out_data(m_tdata)
  );

  assign s_tready = cmd.ready;

  // No beat is taken during the clearing pass
  `RCH_ASSERT_NOW(a_no_accept_in_clear, cmd.clr_step, !s_tready)
  // An accepted beat is looked up in the next cycle
  `RCH_ASSERT_NEXT(a_lookup_follows, s_tvalid && s_tready, cmd.rd_en)
  // A result is only loaded into a free output register
  `RCH_ASSERT_NOW(a_load_when_free, cmd.load_out, sts.out_free)
  // A loaded result is presented in the next cycle
  `RCH_ASSERT_NEXT(a_result_shown, cmd.load_out, m_tvalid)

endmodule

`default_nettype wire

FILE: bench/tb_rgb_channel_histogram_unit.sv
// Self-checking bench for rgb_channel_histogram_unit: pixel and bin-read beats
// on the stream input, predicted bin counts checked on the stream output.
// Depends on rch_pkg and the RTL under hdl/.
`timescale 1ns / 100ps

module tb_rgb_channel_histogram_unit;
  import rch_pkg::*;

  // Full-width counters, same as the block's default build
  localparam int HIST_COUNT_BITS = COUNT_BITS_DEF;
  localparam int STALL_LIMIT     = 2000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES    = 16;
  localparam int MAX_GAP         = 30;
  localparam int HOT_BIN_PIXELS  = 100;

  typedef logic [HIST_COUNT_BITS-1:0] hist_count_t;

  // One input beat, fields as the block sees them
  typedef struct packed {
    logic                req_type;
    logic                clear_after_read;
    logic [BIN_BITS-1:0] bin_index;
    logic [7:0]          blue;
    logic [7:0]          green;
    logic [7:0]          red;
  } hist_req_t;

  // One output beat, laid out like m_tdata (lowest field last)
  typedef struct packed {
    logic [OUT_COUNT_BITS-1:0] blue_count;
    logic [OUT_COUNT_BITS-1:0] green_count;
    logic [OUT_COUNT_BITS-1:0] red_count;
    logic [BIN_BITS-1:0]       bin_number;
  } hist_bin_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    s_tvalid = 1'b0;
  logic                    s_tready;
  logic [S_TDATA_BITS-1:0] s_tdata = '0;
  logic                    s_tuser = 1'b0;
  logic                    m_tvalid;
  logic                    m_tready = 1'b0;
  logic [M_TDATA_BITS-1:0] m_tdata;

  // Shadow histograms and the bin reads still owed by the block
  hist_count_t red_hist   [NUM_BINS];
  hist_count_t green_hist [NUM_BINS];
  hist_count_t blue_hist  [NUM_BINS];
  hist_bin_t   pending_bin_counts [$];

  int fail_count        = 0;
  int tx_idle_pct       = 0;
  int rx_idle_pct       = 0;
  int hold_off_requests = 0;
  int hold_off_served   = 0;
  int hold_left         = 0;
  int stall_cycles      = 0;

  rgb_channel_histogram_unit #(
    .COUNT_BITS(HIST_COUNT_BITS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  // Count widened or truncated to the 24-bit output field
  function automatic logic [OUT_COUNT_BITS-1:0] to_out_count(input hist_count_t cnt);
    logic [31:0] wide;
    wide = 32'(cnt);
    return wide[OUT_COUNT_BITS-1:0];
  endfunction

  // Update the shadow histograms for one accepted beat; queue a read result
  function automatic void apply_to_histograms(input hist_req_t req);
    hist_bin_t res;
    if (req.req_type == REQ_ACCUM) begin
      if (red_hist[req.red] != '1) red_hist[req.red] += 1'b1;
      if (green_hist[req.green] != '1) green_hist[req.green] += 1'b1;
      if (blue_hist[req.blue] != '1) blue_hist[req.blue] += 1'b1;
    end else begin
      res.bin_number  = req.bin_index;
      res.red_count   = to_out_count(red_hist[req.bin_index]);
      res.green_count = to_out_count(green_hist[req.bin_index]);
      res.blue_count  = to_out_count(blue_hist[req.bin_index]);
      pending_bin_counts.push_back(res);
      if (req.clear_after_read) begin
        red_hist[req.bin_index]   = '0;
        green_hist[req.bin_index] = '0;
        blue_hist[req.bin_index]  = '0;
      end
    end
  endfunction

  function automatic void check_field(input string name, input int unsigned exp,
                                      input int unsigned act);
    if (exp != act) begin
      $error("%s: expected %0d, got %0d", name, exp, act);
      fail_count++;
    end
  endfunction

  function automatic void check_bin_counts(input hist_bin_t got);
    hist_bin_t exp;
    if (pending_bin_counts.size() == 0) begin
      $error("unexpected result beat for bin %0d", got.bin_number);
      fail_count++;
    end else begin
      exp = pending_bin_counts.pop_front();
      check_field("bin_number", exp.bin_number, got.bin_number);
      check_field("red_count", exp.red_count, got.red_count);
      check_field("green_count", exp.green_count, got.green_count);
      check_field("blue_count", exp.blue_count, got.blue_count);
    end
  endfunction

  // Input side monitor: predict on every accepted beat
  always @(posedge clk) begin
    hist_req_t req;
    if (!rst && s_tvalid && s_tready) begin
      req.req_type         = s_tuser;
      req.red              = s_tdata[7:0];
      req.green            = s_tdata[15:8];
      req.blue             = s_tdata[23:16];
      req.bin_index        = s_tdata[31:24];
      req.clear_after_read = s_tdata[32];
      apply_to_histograms(req);
    end
  end

  // Output side: check accepted beats, drive tready with random idling and hold-offs
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) check_bin_counts(hist_bin_t'(m_tdata));
    if (hold_off_served != hold_off_requests) begin
      hold_off_served = hold_off_requests;
      hold_left       = HOLD_OFF_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Watchdog on cycles without any beat on either side
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Offer one beat after an optional idle gap, return once s_tready is seen high after an edge
  task automatic send_req(input hist_req_t req);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req.req_type;
    s_tdata  <= {7'b0, req.clear_after_read, req.bin_index, req.blue, req.green, req.red};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Pixel beat; the read-only fields carry random junk
  function automatic hist_req_t make_pixel(input logic [7:0] r, input logic [7:0] g,
                                           input logic [7:0] b);
    hist_req_t req;
    req.req_type         = REQ_ACCUM;
    req.red              = r;
    req.green            = g;
    req.blue             = b;
    req.bin_index        = 8'($urandom);
    req.clear_after_read = 1'($urandom);
    return req;
  endfunction

  // Bin read beat; the pixel fields carry random junk
  function automatic hist_req_t make_read(input logic [BIN_BITS-1:0] idx, input logic clr);
    hist_req_t req;
    req.req_type         = REQ_READ;
    req.red              = 8'($urandom);
    req.green            = 8'($urandom);
    req.blue             = 8'($urandom);
    req.bin_index        = idx;
    req.clear_after_read = clr;
    return req;
  endfunction

  // Sample biased toward a few hot bins so counts build up
  function automatic logic [7:0] pick_sample();
    if ($urandom_range(99) >= 40) return 8'($urandom);
    case ($urandom_range(3))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h55;
      default: return 8'hAA;
    endcase
  endfunction

  task automatic test_cleared_after_reset();
    send_req(make_read(8'd0, 1'b0));
    send_req(make_read(8'd255, 1'b0));
    send_req(make_read(8'd128, 1'b0));
  endtask

  // Extreme samples, ignored fields on both kinds, read with and without clear
  task automatic test_channel_extremes();
    hist_req_t req;
    send_req(make_pixel(8'h00, 8'hFF, 8'h00));
    send_req(make_pixel(8'hFF, 8'h00, 8'hFF));
    req = make_pixel(8'h00, 8'h00, 8'h00);
    req.bin_index        = 8'hFF;
    req.clear_after_read = 1'b1;
    send_req(req);
    req = make_read(8'h00, 1'b0);
    req.red   = 8'hFF;
    req.green = 8'hFF;
    req.blue  = 8'hFF;
    send_req(req);
    send_req(make_read(8'hFF, 1'b0));
    send_req(make_read(8'h00, 1'b1));
    send_req(make_read(8'h00, 1'b0));
    send_req(make_read(8'hFF, 1'b1));
    send_req(make_read(8'hFF, 1'b0));
  endtask

  // Back-to-back updates of one bin, read and clear right behind them
  task automatic test_forwarding();
    repeat (3) send_req(make_pixel(8'd9, 8'd9, 8'd9));
    send_req(make_read(8'd9, 1'b1));
    send_req(make_pixel(8'd9, 8'd10, 8'd9));
    send_req(make_read(8'd9, 1'b0));
    send_req(make_pixel(8'd10, 8'd9, 8'd10));
    send_req(make_read(8'd10, 1'b1));
    send_req(make_read(8'd9, 1'b1));
  endtask

  // Build up one bin per channel, read it, then clear it
  task automatic test_hot_bin();
    repeat (HOT_BIN_PIXELS) send_req(make_pixel(8'd3, 8'd200, 8'd77));
    send_req(make_read(8'd3, 1'b0));
    send_req(make_read(8'd200, 1'b0));
    send_req(make_pixel(8'd3, 8'd200, 8'd77));
    send_req(make_read(8'd77, 1'b1));
    send_req(make_read(8'd3, 1'b1));
    send_req(make_read(8'd200, 1'b1));
    send_req(make_read(8'd3, 1'b0));
  endtask

  // Long receiver hold-off while reads keep coming, so the input stalls
  task automatic test_output_backpressure();
    hold_off_requests++;
    repeat (40) begin
      if ($urandom_range(3) == 0) send_req(make_pixel(pick_sample(), pick_sample(),
                                                      pick_sample()));
      else send_req(make_read(pick_sample(), 1'($urandom)));
    end
  endtask

  task automatic run_mixed_traffic(input int n_beats);
    repeat (n_beats) begin
      if ($urandom_range(99) < 72) send_req(make_pixel(pick_sample(), pick_sample(),
                                                       pick_sample()));
      else send_req(make_read(pick_sample(), ($urandom_range(99) < 30)));
    end
  endtask

  // Read out and clear every bin, then confirm a few are empty
  task automatic test_drain_all_bins();
    for (int i = 0; i < NUM_BINS; i++) send_req(make_read(BIN_BITS'(i), 1'b1));
    send_req(make_read(8'h00, 1'b0));
    send_req(make_read(8'hAA, 1'b0));
    send_req(make_read(8'hFF, 1'b0));
  endtask

  initial begin
    for (int i = 0; i < NUM_BINS; i++) begin
      red_hist[i]   = '0;
      green_hist[i] = '0;
      blue_hist[i]  = '0;
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    tx_idle_pct = 19;
    rx_idle_pct = 88;
    test_cleared_after_reset();
    test_channel_extremes();
    test_forwarding();
    run_mixed_traffic(500);

    tx_idle_pct = 88;
    rx_idle_pct = 19;
    run_mixed_traffic(500);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_hot_bin();
    test_output_backpressure();
    run_mixed_traffic(400);
    test_drain_all_bins();

    s_tvalid <= 1'b0;
    while (pending_bin_counts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
